FILE: hdl/mfwr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package mfwr_pkg;

  // Sequencer states, one-hot.
  typedef enum logic [10:0] {
    ST_IDLE = 11'b000_0000_0001,
    ST_PREP = 11'b000_0000_0010,
    ST_MAG  = 11'b000_0000_0100,
    ST_SAT  = 11'b000_0000_1000,
    ST_MDIV = 11'b000_0001_0000,
    ST_MUL  = 11'b000_0010_0000,
    ST_DROP = 11'b000_0100_0000,
    ST_ADD  = 11'b000_1000_0000,
    ST_RSET = 11'b001_0000_0000,
    ST_RDIV = 11'b010_0000_0000,
    ST_FIN  = 11'b100_0000_0000
  } state_t;

  localparam int IN_W         = 32;  // price and volume port width
  localparam int VOL_W        = 32;
  localparam int WL_W         = 6;   // window register width
  localparam int WINDOW_RESET = 20;
  localparam int MULT_W       = 18;  // signed Q1.16 multiplier incl. +1.0
  localparam int PROD_W       = 50;  // multiplier * volume
  localparam int ENTRY_W      = PROD_W + VOL_W + 1;
  localparam int PSUM_W       = 57;  // up to 63 products, signed
  localparam int VSUM_W       = 38;  // up to 63 volumes
  localparam int QW           = 17;  // ratio quotient bits (0..65536)
  localparam int MQ_W         = 16;  // multiplier quotient bits
  localparam int RATIO_W      = 18;
  localparam int Q_ONE        = 65536;

endpackage
`default_nettype wire

FILE: hdl/money_flow_window_ratio_top.sv
`timescale 1ns / 1ps
`default_nettype none
// Windowed money flow ratio. Each input request is one price bar (high, low,
// close in ticks, plus volume); each bar yields exactly one result request
// holding sum(multiplier*volume)/sum(volume) over the last window_length
// bars in signed Q1.16, with ratio_valid set only when the window is full,
// every bar in it had high > low, and the volume sum is nonzero (flow_ratio
// is 0 otherwise). The per-bar multiplier (2c-h-l)/(h-l) is truncated toward
// zero and saturated to +/-1.0. A bar with no range skips the multiplier
// quotient, and the ratio quotient is worked out only for a valid window.
// in_ready comes back in the cycle after the result is loaded, so bars do
// not overlap: a single 39-bit subtract/compare unit is reused for 16
// restoring steps of the multiplier quotient and 17 steps of the window
// ratio quotient, and in_ready stays low for that whole time.
// A finished result sits in an output register, so the next bar is taken
// while the result waits for out_ready; that next bar then holds in its last
// step until the register is free.
// Writing window_length (0 is taken as 1, values above MAX_WINDOW as
// MAX_WINDOW) restarts the history at once; no memory clearing pass is
// needed because ring entries are only read back after they are rewritten.
// Write it only while no bar is in flight.
module money_flow_window_ratio_top #(
  parameter int MAX_WINDOW = 32,
  parameter int PRICE_BITS = 32
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  // bar input
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic [31:0]          high_price,
  input  wire logic [31:0]          low_price,
  input  wire logic [31:0]          close_price,
  input  wire logic [31:0]          volume,
  // result output
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic signed [17:0]        flow_ratio,
  output logic                      ratio_valid,
  // window length write
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [5:0]           window_length
);

  // Price bits actually used: the ports carry at most 32.
  localparam int PW = (PRICE_BITS < mfwr_pkg::IN_W) ? PRICE_BITS : mfwr_pkg::IN_W;
  localparam int AW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  // Shared unit width: covers ratio remainders and multiplier magnitudes.
  localparam int DW = (mfwr_pkg::VSUM_W + 1 > PW + 2) ? mfwr_pkg::VSUM_W + 1 : PW + 2;
  localparam int WL_W   = mfwr_pkg::WL_W;
  localparam int QW     = mfwr_pkg::QW;
  localparam int PROD_W = mfwr_pkg::PROD_W;
  localparam int PSUM_W = mfwr_pkg::PSUM_W;
  localparam int VSUM_W = mfwr_pkg::VSUM_W;
  localparam int VOL_W  = mfwr_pkg::VOL_W;
  localparam int MULT_W = mfwr_pkg::MULT_W;

  mfwr_pkg::state_t state;

  // configuration and history bookkeeping
  logic [WL_W-1:0]          wl;
  logic [WL_W-1:0]          ptr;
  logic [WL_W-1:0]          fill;
  logic [WL_W-1:0]          icnt;
  logic signed [PSUM_W-1:0] psum;
  logic [VSUM_W-1:0]        vsum;

  // bar being worked on
  logic [PW-1:0]            hp;
  logic [PW-1:0]            lp;
  logic [PW-1:0]            cp;
  logic [VOL_W-1:0]         vol;
  logic [PW:0]              hl;
  logic                     bad;
  logic                     neg;
  logic                     sat;
  logic signed [PROD_W-1:0] prod;

  // divider datapath
  logic [DW-1:0]            rem;
  logic [DW-1:0]            dvsr;
  logic [QW-1:0]            lo;
  logic [4:0]               cnt;
  logic                     ok;
  logic                     pneg;

  // ring memory
  logic [AW-1:0]                   slot;
  logic [mfwr_pkg::ENTRY_W-1:0]    rd_entry;
  logic [mfwr_pkg::ENTRY_W-1:0]    wr_entry;
  logic signed [PROD_W-1:0]        old_prod;
  logic [VOL_W-1:0]                old_vol;
  logic                            old_inv;
  logic                            ram_we;

  // shared subtract / compare unit
  logic [DW-1:0]            alu_a;
  logic [DW:0]              alu_diff;
  logic                     alu_ge;

  // misc combinational
  logic                     in_acc;
  logic                     cfg_acc;
  logic                     full;
  logic [PW:0]              c2;
  logic [QW-1:0]            mq;
  logic signed [MULT_W-1:0] mfm;
  logic signed [PROD_W:0]   mult;
  logic [PSUM_W-1:0]        apsum;
  logic [QW-1:0]            rq;
  logic signed [mfwr_pkg::RATIO_W-1:0] ratio;
  logic [WL_W-1:0]          wl_next;
  logic [31:0]              ptr_inc;

  assign in_ready  = (state == mfwr_pkg::ST_IDLE) && !cfg_valid;
  assign cfg_ready = (state == mfwr_pkg::ST_IDLE);
  assign in_acc    = in_valid && in_ready;
  assign cfg_acc   = cfg_valid && cfg_ready;
  assign full      = (fill >= wl);

  // Pointers past the ring wrap to slot 0.
  assign slot    = (32'(ptr) >= 32'(MAX_WINDOW)) ? '0 : AW'(32'(ptr));
  assign ptr_inc = 32'(slot) + 32'd1;

  assign old_prod = $signed(rd_entry[mfwr_pkg::ENTRY_W-1 -: PROD_W]);
  assign old_vol  = rd_entry[VOL_W:1];
  assign old_inv  = rd_entry[0];
  assign wr_entry = {prod, vol, bad};
  assign ram_we   = (state == mfwr_pkg::ST_ADD);

  mfwr_ram #(
    .WIDTH (mfwr_pkg::ENTRY_W),
    .DEPTH (MAX_WINDOW)
  ) u_ring (
    .clk   (clk),
    .we    (ram_we),
    .waddr (slot),
    .wdata (wr_entry),
    .raddr (slot),
    .rdata (rd_entry)
  );

  // Shared unit: plain compare in SAT, shift-and-compare in divide steps.
  always_comb begin
    if (state == mfwr_pkg::ST_SAT) begin
      alu_a = rem;
    end else begin
      alu_a = {rem[DW-2:0], lo[QW-1]};
    end
    alu_diff = {1'b0, alu_a} - {1'b0, dvsr};
    alu_ge   = !alu_diff[DW];
  end

  always_comb begin
    c2  = {cp, 1'b0};
    mq  = sat ? QW'(mfwr_pkg::Q_ONE) : {1'b0, lo[mfwr_pkg::MQ_W-1:0]};
    if (bad) begin
      mfm = '0;
    end else if (neg) begin
      mfm = -$signed({1'b0, mq});
    end else begin
      mfm = $signed({1'b0, mq});
    end
    mult  = mfm * $signed({1'b0, vol});
    apsum = psum[PSUM_W-1] ? PSUM_W'(-psum) : PSUM_W'(psum);
    rq    = (lo > QW'(mfwr_pkg::Q_ONE)) ? QW'(mfwr_pkg::Q_ONE) : lo;
    if (!ok) begin
      ratio = '0;
    end else if (pneg) begin
      ratio = -$signed({1'b0, rq});
    end else begin
      ratio = $signed({1'b0, rq});
    end
    if (window_length == '0) begin
      wl_next = WL_W'(1);
    end else if (32'(window_length) > 32'(MAX_WINDOW)) begin
      wl_next = WL_W'(MAX_WINDOW);
    end else begin
      wl_next = window_length;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= mfwr_pkg::ST_IDLE;
      wl        <= WL_W'(mfwr_pkg::WINDOW_RESET);
      ptr       <= '0;
      fill      <= '0;
      icnt      <= '0;
      psum      <= '0;
      vsum      <= '0;
      out_valid <= 1'b0;
    end else begin
      // FIN reloads the output register itself
      if (out_valid && out_ready && (state != mfwr_pkg::ST_FIN)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        mfwr_pkg::ST_IDLE: begin
          if (cfg_acc) begin
            wl   <= wl_next;
            ptr  <= '0;
            fill <= '0;
            icnt <= '0;
            psum <= '0;
            vsum <= '0;
          end else if (in_acc) begin
            hp    <= high_price[PW-1:0];
            lp    <= low_price[PW-1:0];
            cp    <= close_price[PW-1:0];
            vol   <= volume;
            state <= mfwr_pkg::ST_PREP;
          end
        end
        mfwr_pkg::ST_PREP: begin
          hl    <= {1'b0, hp} + {1'b0, lp};
          dvsr  <= DW'(hp - lp);
          bad   <= (hp <= lp);
          state <= (hp <= lp) ? mfwr_pkg::ST_MUL : mfwr_pkg::ST_MAG;
        end
        mfwr_pkg::ST_MAG: begin
          neg   <= (c2 < hl);
          rem   <= (c2 < hl) ? DW'(hl - c2) : DW'(c2 - hl);
          sat   <= 1'b0;
          state <= mfwr_pkg::ST_SAT;
        end
        mfwr_pkg::ST_SAT: begin
          // close outside the range: multiplier pins at +/-1.0
          lo <= '0;
          if (alu_ge) begin
            sat   <= 1'b1;
            state <= mfwr_pkg::ST_MUL;
          end else begin
            cnt   <= 5'(mfwr_pkg::MQ_W - 1);
            state <= mfwr_pkg::ST_MDIV;
          end
        end
        mfwr_pkg::ST_MDIV, mfwr_pkg::ST_RDIV: begin
          rem <= alu_ge ? alu_diff[DW-1:0] : alu_a;
          lo  <= {lo[QW-2:0], alu_ge};
          cnt <= cnt - 5'd1;
          if (cnt == '0) begin
            state <= (state == mfwr_pkg::ST_MDIV) ? mfwr_pkg::ST_MUL : mfwr_pkg::ST_FIN;
          end
        end
        mfwr_pkg::ST_MUL: begin
          prod  <= mult[PROD_W-1:0];
          state <= mfwr_pkg::ST_DROP;
        end
        mfwr_pkg::ST_DROP: begin
          // retire the oldest bar once the window is full
          if (full) begin
            psum <= psum - {{(PSUM_W-PROD_W){old_prod[PROD_W-1]}}, old_prod};
            vsum <= vsum - VSUM_W'(old_vol);
            icnt <= icnt - WL_W'(old_inv);
          end else begin
            fill <= fill + WL_W'(1);
          end
          state <= mfwr_pkg::ST_ADD;
        end
        mfwr_pkg::ST_ADD: begin
          psum  <= psum + {{(PSUM_W-PROD_W){prod[PROD_W-1]}}, prod};
          vsum  <= vsum + VSUM_W'(vol);
          icnt  <= icnt + WL_W'(bad);
          ptr   <= (ptr_inc >= 32'(wl)) ? '0 : WL_W'(ptr_inc);
          state <= mfwr_pkg::ST_RSET;
        end
        mfwr_pkg::ST_RSET: begin
          ok   <= full && (icnt == '0) && (vsum != '0);
          pneg <= psum[PSUM_W-1];
          rem  <= DW'(apsum >> QW);
          lo   <= apsum[QW-1:0];
          dvsr <= DW'(vsum);
          cnt  <= 5'(QW - 1);
          if (full && (icnt == '0) && (vsum != '0)) begin
            state <= mfwr_pkg::ST_RDIV;
          end else begin
            state <= mfwr_pkg::ST_FIN;
          end
        end
        mfwr_pkg::ST_FIN: begin
          if (!out_valid || out_ready) begin
            flow_ratio  <= ratio;
            ratio_valid <= ok;
            out_valid   <= 1'b1;
            state       <= mfwr_pkg::ST_IDLE;
          end
        end
        default: begin
          state <= mfwr_pkg::ST_IDLE;
        end
      endcase
    end
  end

  // A taken bar keeps the input closed on the following cycle.
  a_busy_after_accept : assert property (@(posedge clk) disable iff (rst)
    in_acc |=> !in_ready)
    else $error("input ready right after a bar was taken");

  // An invalid result carries a zero ratio.
  a_zero_when_invalid : assert property (@(posedge clk) disable iff (rst)
    (out_valid && !ratio_valid) |-> (flow_ratio == '0))
    else $error("nonzero ratio on invalid result");

  // Valid ratios stay within +/-1.0.
  a_ratio_bounded : assert property (@(posedge clk) disable iff (rst)
    (out_valid && ratio_valid) |->
      (flow_ratio <= 18'sd65536 && flow_ratio >= -18'sd65536))
    else $error("ratio outside +/-1.0");

  // Bars in the window never exceed the window length.
  a_fill_bounded : assert property (@(posedge clk) disable iff (rst)
    fill <= wl)
    else $error("fill count above window length");

  // A new result is only loaded when the output register is free.
  a_no_overwrite : assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(flow_ratio)))
    else $error("pending result overwritten");

endmodule
`default_nettype wire

FILE: hdl/mfwr_ram.sv
`timescale 1ns / 1ps
`default_nettype none
module mfwr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  wire logic                                     clk,
  input  wire logic                                     we,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                         wdata,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

FILE: test/flow_ratio_checker.sv
`timescale 1ns / 1ps
module flow_ratio_checker #(
  parameter int MAX_WINDOW = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic [31:0]        high_price,
  input  logic [31:0]        low_price,
  input  logic [31:0]        close_price,
  input  logic [31:0]        volume,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic signed [17:0] flow_ratio,
  input  logic               ratio_valid,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic [5:0]         window_length,
  output int                 mismatches,
  output int                 bars_in_flight
);

  localparam int REPORT_LIMIT = 10;

  typedef struct {
    logic signed [mfwr_pkg::RATIO_W-1:0] ratio;
    logic                                valid;
  } ratio_result_t;

  ratio_result_t pending_ratios[$];

  // window history
  longint ring_product [MAX_WINDOW];
  longint ring_volume  [MAX_WINDOW];
  bit     ring_bad     [MAX_WINDOW];
  longint product_total;
  longint volume_total;
  int     bad_count;
  int     slot_ptr;
  int     bars_held;
  int     window_len;
  int     mismatch_count = 0;

  assign mismatches = mismatch_count;

  task automatic clear_window_history();
    product_total = 0;
    volume_total  = 0;
    bad_count     = 0;
    slot_ptr      = 0;
    bars_held     = 0;
  endtask

  task automatic apply_window(input logic [5:0] wl);
    int len;
    len = wl;
    if (len == 0) len = 1;
    if (len > MAX_WINDOW) len = MAX_WINDOW;
    window_len = len;
    clear_window_history();
  endtask

  task automatic predict_bar(input logic [31:0] h, l, c, v);
    longint span, num, mag, mult, prod, quot;
    bit bad;
    ratio_result_t res;
    span = longint'({32'd0, h}) - longint'({32'd0, l});
    bad  = (h <= l);
    mult = 0;
    if (!bad) begin
      num  = 2 * longint'({32'd0, c}) - longint'({32'd0, h}) - longint'({32'd0, l});
      mag  = (num < 0) ? -num : num;
      // truncate magnitude, then apply sign; close outside range saturates
      mult = (mag >= span) ? longint'(mfwr_pkg::Q_ONE) : (mag << 16) / span;
      if (num < 0) mult = -mult;
    end
    prod = mult * longint'({32'd0, v});

    if (bars_held >= window_len) begin
      product_total -= ring_product[slot_ptr];
      volume_total  -= ring_volume[slot_ptr];
      bad_count     -= ring_bad[slot_ptr];
    end else begin
      bars_held++;
    end
    ring_product[slot_ptr] = prod;
    ring_volume[slot_ptr]  = longint'({32'd0, v});
    ring_bad[slot_ptr]     = bad;
    product_total += prod;
    volume_total  += longint'({32'd0, v});
    bad_count     += bad;
    slot_ptr = (slot_ptr + 1 >= window_len) ? 0 : slot_ptr + 1;

    res.valid = (bars_held >= window_len) && (bad_count == 0) && (volume_total != 0);
    res.ratio = '0;
    if (res.valid) begin
      quot = product_total / volume_total;
      if (quot > mfwr_pkg::Q_ONE) quot = mfwr_pkg::Q_ONE;
      if (quot < -mfwr_pkg::Q_ONE) quot = -mfwr_pkg::Q_ONE;
      res.ratio = quot[17:0];
    end
    pending_ratios.insert(pending_ratios.size(), res);
  endtask

  task automatic check_result();
    ratio_result_t want;
    if (pending_ratios.size() == 0) begin
      mismatch_count++;
      if (mismatch_count <= REPORT_LIMIT)
        $display("%0t: unexpected result: ratio %0d valid %0b", $realtime, flow_ratio,
                 ratio_valid);
    end else begin
      want = pending_ratios.pop_front();
      if (want.ratio !== flow_ratio || want.valid !== ratio_valid) begin
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT)
          $display("%0t: result mismatch: expected ratio %0d valid %0b, got ratio %0d valid %0b",
                   $realtime, want.ratio, want.valid, flow_ratio, ratio_valid);
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      window_len = mfwr_pkg::WINDOW_RESET;
      clear_window_history();
      pending_ratios.delete();
    end else begin
      if (cfg_valid && cfg_ready) apply_window(window_length);
      if (in_valid && in_ready) predict_bar(high_price, low_price, close_price, volume);
      if (out_valid && out_ready) check_result();
    end
    bars_in_flight <= pending_ratios.size();
  end

endmodule

FILE: test/tb.sv
`timescale 1ns / 1ps
module tb;

  localparam int STALL_LIMIT = 4000;  // quiet cycles before declaring a hang
  localparam int HOLD_CYCLES = 300;   // long output back-pressure stretch
  localparam int PHASE_BARS  = 140;
  localparam int PHASES      = 10;

  // window settings for each random phase but the last; includes both ends and out-of-range codes
  localparam logic [5:0] WINDOW_PLAN [PHASES] = '{
    6'd32, 6'd1, 6'd63, 6'd0, 6'd2, 6'd5, 6'd33, 6'd17, 6'd31, 6'd4
  };

  typedef struct packed {
    logic [31:0] high;
    logic [31:0] low;
    logic [31:0] close;
    logic [31:0] vol;
  } bar_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [31:0]        high_price = '0;
  logic [31:0]        low_price = '0;
  logic [31:0]        close_price = '0;
  logic [31:0]        volume = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic signed [17:0] flow_ratio;
  logic               ratio_valid;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [5:0]         window_length = '0;

  int  mismatches;
  int  bars_in_flight;
  int  quiet_cycles = 0;
  bit  tx_idle = 1'b1;       // sender inserts random gaps
  bit  rx_idle = 1'b1;       // receiver inserts random stalls
  bit  hold_request = 1'b0;  // ask the receiver for one long hold-off

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  money_flow_window_ratio_top dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .high_price   (high_price),
    .low_price    (low_price),
    .close_price  (close_price),
    .volume       (volume),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .flow_ratio   (flow_ratio),
    .ratio_valid  (ratio_valid),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .window_length(window_length)
  );

  flow_ratio_checker u_checker (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .high_price    (high_price),
    .low_price     (low_price),
    .close_price   (close_price),
    .volume        (volume),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .flow_ratio    (flow_ratio),
    .ratio_valid   (ratio_valid),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .window_length (window_length),
    .mismatches    (mismatches),
    .bars_in_flight(bars_in_flight)
  );

  // Synchronous reset, held at the start and never asserted again.
  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
  end

  // Hang detector: any accepted request on any channel clears the count.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("money_flow_window_ratio_top regression: fail");
      $finish;
    end
  end

  // Result side. Each request gets its own stall draw; a pending hold request
  // replaces the draw with one long hold-off so the block backs up and drops
  // in_ready while the sender keeps offering bars.
  initial begin
    int unsigned stall;
    forever begin
      if (hold_request) begin
        stall = HOLD_CYCLES;
        hold_request = 1'b0;
      end else begin
        stall = rx_idle ? $urandom_range(0, 18) : 0;
      end
      if (stall != 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  // Mostly well-formed bars (high > low) so full windows actually produce
  // valid ratios; a few no-range bars poison the window now and then.
  function automatic bar_t random_bar();
    bar_t b;
    int unsigned shape, a, z;
    shape = $urandom_range(0, 99);
    if (shape < 2) begin
      // no range: high at or below low
      a = $urandom;
      z = $urandom_range(0, 1) ? a : $urandom;
      b.high = (a < z) ? a : z;
      b.low  = (a < z) ? z : a;
    end else if (shape < 40) begin
      b.low  = $urandom_range(0, 100000);
      b.high = b.low + $urandom_range(1, 5000);
    end else if (shape < 80) begin
      a = $urandom;
      z = $urandom;
      if (a == z) z = a ^ 32'h1;
      b.high = (a > z) ? a : z;
      b.low  = (a > z) ? z : a;
    end else begin
      // prices near the top of the tick range
      b.high = 32'hFFFF_FFFF - $urandom_range(0, 2000);
      b.low  = b.high - $urandom_range(1, 100000);
    end

    shape = $urandom_range(0, 99);
    if (shape < 70)      b.close = b.low + $urandom_range(0, b.high - b.low);
    else if (shape < 78) b.close = $urandom;  // usually outside the range
    else if (shape < 84) b.close = b.low;
    else if (shape < 90) b.close = b.high;
    else                 b.close = b.low + (b.high - b.low) / 2;

    shape = $urandom_range(0, 99);
    if (shape < 5)       b.vol = '0;
    else if (shape < 10) b.vol = 32'hFFFF_FFFF;
    else if (shape < 40) b.vol = $urandom_range(1, 1000);
    else                 b.vol = $urandom;
    return b;
  endfunction

  // One bar request. A zero gap keeps in_valid high straight into the next
  // bar, so in_valid sees a single assignment per edge.
  task automatic send_bar(input bar_t b);
    int unsigned gap;
    gap = tx_idle ? $urandom_range(0, 18) : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    high_price  <= b.high;
    low_price   <= b.low;
    close_price <= b.close;
    volume      <= b.vol;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Stop sending and wait until every predicted result has been taken.
  // bars_in_flight is registered, so it is read only after the next edge.
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (bars_in_flight != 0) @(posedge clk);
  endtask

  // Window write; only issued with the block drained.
  task automatic write_window(input logic [5:0] wl);
    cfg_valid     <= 1'b1;
    window_length <= wl;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    int p;
    int n;
    @(posedge clk);
    while (rst) @(posedge clk);

    // reset window (20) before any register write
    repeat (60) send_bar(random_bar());
    drain_results();

    // Window of one: every result is the bar's own multiplier, so the
    // multiplier corner cases show up directly.
    write_window(6'd1);
    send_bar('{32'd1, 32'd0, 32'd1, 32'd1});                     // +1.0
    send_bar('{32'd1, 32'd0, 32'd0, 32'hFFFF_FFFF});             // -1.0
    send_bar('{32'hFFFF_FFFF, 32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF});
    send_bar('{32'hFFFF_FFFF, 32'd0, 32'd0, 32'hFFFF_FFFF});
    send_bar('{32'hFFFF_FFFF, 32'd0, 32'h7FFF_FFFF, 32'd77});    // tiny negative -> 0
    send_bar('{32'hFFFF_FFFF, 32'hFFFF_FFFE, 32'hFFFF_FFFF, 32'd5});
    send_bar('{32'd12345, 32'd12345, 32'd12345, 32'd100});       // zero range
    send_bar('{32'd0, 32'hFFFF_FFFF, 32'd0, 32'd9});             // high below low
    send_bar('{32'd0, 32'd0, 32'd0, 32'd0});
    send_bar('{32'd200, 32'd100, 32'd150, 32'd40});              // exact midpoint
    send_bar('{32'd3, 32'd0, 32'd1, 32'd3});                     // truncation, negative
    send_bar('{32'd3, 32'd0, 32'd2, 32'd3});                     // truncation, positive
    send_bar('{32'd10, 32'd5, 32'hFFFF_FFFF, 32'd8});            // close far above
    send_bar('{32'd10, 32'd5, 32'd0, 32'd8});                    // close far below
    send_bar('{32'd10, 32'd5, 32'd7, 32'd0});                    // zero volume sum
    send_bar('{32'd7, 32'd0, 32'd6, 32'd1});
    send_bar('{32'hFFFF_FFFF, 32'd1, 32'h8000_0000, 32'd12345});
    send_bar('{32'hAAAA_AAAA, 32'h5555_5555, 32'h5555_AAAA, 32'hAAAA_AAAA});
    send_bar('{32'hD555_5555, 32'h2AAA_AAAA, 32'hAAAA_5555, 32'h5555_5555});
    drain_results();

    // Window of two: a bad bar stays in the window for one more bar, then
    // zero-volume pairs, then a mix of opposite multipliers.
    write_window(6'd2);
    send_bar('{32'd50, 32'd50, 32'd50, 32'd10});
    send_bar('{32'd60, 32'd40, 32'd55, 32'd10});
    send_bar('{32'd60, 32'd40, 32'd45, 32'd30});
    send_bar('{32'd60, 32'd40, 32'd60, 32'd0});
    send_bar('{32'd60, 32'd40, 32'd40, 32'd0});
    send_bar('{32'd9, 32'd1, 32'd9, 32'hFFFF_FFFF});
    send_bar('{32'd9, 32'd1, 32'd1, 32'd3});

    // Random phases, each with its own window and idle pattern, including
    // stretches with no gaps on one or both sides.
    for (p = 0; p < PHASES; p++) begin
      drain_results();
      tx_idle = (p % 4) < 2;
      rx_idle = (p % 4) == 0 || (p % 4) == 2;
      write_window((p == PHASES - 1) ? 6'($urandom_range(0, 63)) : WINDOW_PLAN[p]);
      for (n = 0; n < PHASE_BARS; n++) begin
        if (p == 2 && n == 40) hold_request = 1'b1;  // back up the block
        if (p == 4 && n == 70) drain_results();      // full pause mid-phase
        send_bar(random_bar());
      end
    end

    drain_results();
    repeat (50) @(posedge clk);
    if (mismatches == 0 && bars_in_flight == 0) begin
      $display("money_flow_window_ratio_top regression: pass");
    end else begin
      $display("money_flow_window_ratio_top regression: fail");
    end
    $finish;
  end

endmodule

FILE: sim.f
hdl/mfwr_pkg.sv
hdl/mfwr_ram.sv
hdl/money_flow_window_ratio_top.sv
test/flow_ratio_checker.sv
test/tb.sv
